// ----- design/ppts_pkg.sv -----
// Shared types and constants of the priority periodic task scheduler.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ppts_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam logic [15:0] PRIO_RESET = 16'hffff;
  localparam logic [31:0] TICK_LEN_RESET = 32'd1000;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [15:0] prio_t;
  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_ENABLE  = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ALREADY = 2'd2,
    ST_NOT_EN  = 2'd3
  } status_t;

endpackage

// ----- design/ppts_if.sv -----
// Handshake channel interfaces for scheduler requests and results.
// Depends on ppts_pkg for the payload types.
`timescale 1ns / 1ps

interface ppts_in_if import ppts_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  slot_t      task_index;
  prio_t      priority_req;
  word_t      period_us;

  modport source (output valid, func, task_index, priority_req, period_us, input ready);
  modport sink (input valid, func, task_index, priority_req, period_us, output ready);
endinterface

interface ppts_out_if import ppts_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       fired;
  slot_t      fired_task;
  logic       last;

  modport source (output valid, status, fired, fired_task, last, input ready);
  modport sink (input valid, status, fired, fired_task, last, output ready);
endinterface

// ----- design/ppts_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on ppts_pkg for the word type.
`timescale 1ns / 1ps

module ppts_div import ppts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient
);

  word_t       quo_r;
  word_t       rem_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        cnt_r <= 6'd32;
      end else if (cnt_r != '0) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/priority_periodic_task_scheduler_core.sv -----
// Top level of the priority periodic task scheduler: sequencer, task tables, result register.
// Depends on ppts_pkg, ppts_if and ppts_div.
`timescale 1ns / 1ps

// The scheduler takes one request at a time and holds in_ch.ready low while it works.
// A tick walks the ordered list one entry per cycle, pausing when a due task waits
// on a stalled result channel. An enable runs the serial divider on the period, then
// inserts the task by priority, moving entries along one at a time. A disable finds
// the task in the list and shifts the entries behind it. Rejected requests go straight
// to the response. No clearing pass runs after reset.
module priority_periodic_task_scheduler_core import ppts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  word_t cfg_wdata,
  ppts_in_if.sink    in_ch,
  ppts_out_if.source out_ch
);

  localparam int LIST_DEPTH = (MAX_TASKS < SLOTS) ? MAX_TASKS : SLOTS;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_INSERT, S_FIND, S_SHIFT, S_WALK, S_RESP
  } state_t;

  state_t             state_r;
  word_t              tick_len_r;
  slot_t              order_r [LIST_DEPTH];
  logic [CNT_W-1:0]   count_r;
  prio_t              prio_r [SLOTS];
  word_t              period_r [SLOTS];
  word_t              left_r [SLOTS];
  logic [SLOTS-1:0]   en_r;
  slot_t              req_task_r;
  prio_t              req_prio_r;
  word_t              req_delay_r;
  logic [CNT_W-1:0]   idx_r;
  logic               pend_valid_r;
  slot_t              pend_task_r;
  status_t            resp_status_r;
  logic               resp_fired_r;
  slot_t              resp_task_r;
  logic               div_start_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_fired_r;
  slot_t              out_task_r;
  logic               out_last_r;

  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W-1:0]   idx_p1;
  slot_t              cur_slot;
  slot_t              prev_slot;
  slot_t              next_slot;
  word_t              left_dec;
  word_t              divisor;
  word_t              quotient;
  logic               div_done;
  logic               load_ok;

  assign idx_m1 = idx_r - CNT_W'(1);
  assign idx_p1 = idx_r + CNT_W'(1);
  assign cur_slot = order_r[idx_r[IDX_W-1:0]];
  assign prev_slot = order_r[idx_m1[IDX_W-1:0]];
  assign next_slot = order_r[idx_p1[IDX_W-1:0]];
  assign left_dec = left_r[cur_slot] - 32'd1;
  assign divisor = (tick_len_r == '0) ? 32'd1 : tick_len_r;
  assign load_ok = !out_valid_r || out_ch.ready;

  ppts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (req_delay_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_len_r <= TICK_LEN_RESET;
      count_r <= '0;
      en_r <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        prio_r[k] <= PRIO_RESET;
      end
      pend_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        tick_len_r <= cfg_wdata;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_task_r <= in_ch.task_index;
            req_prio_r <= in_ch.priority_req;
            req_delay_r <= in_ch.period_us;
            resp_fired_r <= 1'b0;
            resp_task_r <= '0;
            resp_status_r <= ST_OK;
            idx_r <= '0;
            pend_valid_r <= 1'b0;
            unique case (func_t'(in_ch.func))
              FUNC_TICK: begin
                state_r <= S_WALK;
              end
              FUNC_ENABLE: begin
                if (en_r[in_ch.task_index]) begin
                  resp_status_r <= ST_ALREADY;
                  state_r <= S_RESP;
                end else if (count_r == CNT_W'(LIST_DEPTH)) begin
                  resp_status_r <= ST_FULL;
                  state_r <= S_RESP;
                end else begin
                  div_start_r <= 1'b1;
                  state_r <= S_DIV;
                end
              end
              FUNC_DISABLE: begin
                if (!en_r[in_ch.task_index]) begin
                  resp_status_r <= ST_NOT_EN;
                  state_r <= S_RESP;
                end else begin
                  state_r <= S_FIND;
                end
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            period_r[req_task_r] <= (quotient == '0) ? 32'd1 : quotient;
            left_r[req_task_r] <= 32'd1;
            prio_r[req_task_r] <= req_prio_r;
            idx_r <= count_r;
            state_r <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (idx_r != '0 && prio_r[prev_slot] >= req_prio_r) begin
            order_r[idx_r[IDX_W-1:0]] <= prev_slot;
            idx_r <= idx_m1;
          end else begin
            order_r[idx_r[IDX_W-1:0]] <= req_task_r;
            count_r <= count_r + CNT_W'(1);
            en_r[req_task_r] <= 1'b1;
            state_r <= S_RESP;
          end
        end
        S_FIND: begin
          if (idx_r >= count_r) begin
            en_r[req_task_r] <= 1'b0;
            state_r <= S_RESP;
          end else if (cur_slot == req_task_r) begin
            state_r <= S_SHIFT;
          end else begin
            idx_r <= idx_p1;
          end
        end
        S_SHIFT: begin
          if (idx_p1 < count_r) begin
            order_r[idx_r[IDX_W-1:0]] <= next_slot;
            idx_r <= idx_p1;
          end else begin
            count_r <= count_r - CNT_W'(1);
            en_r[req_task_r] <= 1'b0;
            state_r <= S_RESP;
          end
        end
        S_WALK: begin
          if (idx_r >= count_r) begin
            resp_fired_r <= pend_valid_r;
            resp_task_r <= pend_valid_r ? pend_task_r : '0;
            state_r <= S_RESP;
          end else if (left_dec == '0) begin
            if (!pend_valid_r || load_ok) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_status_r <= ST_OK;
                out_fired_r <= 1'b1;
                out_task_r <= pend_task_r;
                out_last_r <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_task_r <= cur_slot;
              left_r[cur_slot] <= period_r[cur_slot];
              idx_r <= idx_p1;
            end
          end else begin
            left_r[cur_slot] <= left_dec;
            idx_r <= idx_p1;
          end
        end
        S_RESP: begin
          if (load_ok) begin
            out_valid_r <= 1'b1;
            out_status_r <= resp_status_r;
            out_fired_r <= resp_fired_r;
            out_task_r <= resp_task_r;
            out_last_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.fired = out_fired_r;
  assign out_ch.fired_task = out_task_r;
  assign out_ch.last = out_last_r;

endmodule

// ----- design/ppts_checker.sv -----
// Port-level assertions for the scheduler top level, attached by a bind statement.
// Depends on ppts_pkg and the top level's channel ports.
`timescale 1ns / 1ps

module ppts_checker import ppts_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_fired,
  input slot_t      out_fired_task,
  input logic       out_last
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Scheduler accepted a request while still busy.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_task) && $stable(out_last))
    else $error("Stalled result changed.");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_task == '0 && out_last)
    else $error("Result without a due task carries a task or is not final.");

  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && !out_fired)
    else $error("Error status on a non-final or fired result.");

endmodule

bind priority_periodic_task_scheduler_core ppts_checker u_ppts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_fired      (out_ch.fired),
  .out_fired_task (out_ch.fired_task),
  .out_last       (out_ch.last)
);

// ----- verif/tb.sv -----
// Self-checking testbench for priority_periodic_task_scheduler_core: directed table, then random.
// Depends on ppts_pkg, ppts_if and the scheduler RTL; predicts every result in its own scoreboard.
`timescale 1ns / 1ps

module tb;
  import ppts_pkg::*;

  typedef struct packed {
    func_t func;
    slot_t task_index;
    prio_t priority_req;
    word_t period_us;
  } req_t;

  typedef struct packed {
    status_t status;
    logic fired;
    slot_t fired_task;
    logic last;
  } res_t;

  typedef struct {
    req_t req;
    logic has_exp;
    status_t exp_status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  word_t cfg_wdata = '0;
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  int unsigned quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  ppts_in_if in_ch();
  ppts_out_if out_ch();

  priority_periodic_task_scheduler_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Scheduler image.
  word_t m_tick_len;
  slot_t m_order[SLOTS];
  int m_count;
  prio_t m_prio[SLOTS];
  word_t m_period[SLOTS];
  word_t m_left[SLOTS];
  bit m_en[SLOTS];
  res_t due_results[$];
  int fixed_status[$];

  function automatic res_t mk(status_t s, logic f, slot_t t, logic l);
    res_t r;
    r.status = s; r.fired = f; r.fired_task = t; r.last = l;
    return r;
  endfunction

  function automatic void sched_reset();
    m_tick_len = TICK_LEN_RESET;
    m_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      m_order[i] = '0; m_prio[i] = PRIO_RESET; m_period[i] = '0;
      m_left[i] = '0; m_en[i] = 1'b0;
    end
  endfunction

  function automatic void schedule(req_t r);
    word_t dv;
    word_t per;
    int pos;
    int n;
    slot_t s;
    n = 0;
    case (r.func)
      FUNC_ENABLE: begin
        if (m_en[r.task_index]) due_results.push_back(mk(ST_ALREADY, 1'b0, '0, 1'b1));
        else if (m_count >= SLOTS) due_results.push_back(mk(ST_FULL, 1'b0, '0, 1'b1));
        else begin
          dv = (m_tick_len == 0) ? 32'd1 : m_tick_len;
          per = r.period_us / dv;
          if (per == 0) per = 32'd1;
          m_period[r.task_index] = per;
          m_left[r.task_index] = 32'd1;
          m_prio[r.task_index] = r.priority_req;
          pos = m_count;
          while (pos > 0 && m_prio[m_order[pos-1]] >= r.priority_req) begin
            m_order[pos] = m_order[pos-1];
            pos--;
          end
          m_order[pos] = r.task_index;
          m_count++;
          m_en[r.task_index] = 1'b1;
          due_results.push_back(mk(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      FUNC_DISABLE: begin
        if (!m_en[r.task_index]) due_results.push_back(mk(ST_NOT_EN, 1'b0, '0, 1'b1));
        else begin
          for (int i = 0; i < m_count; i++) begin
            if (m_order[i] == r.task_index) begin
              for (int j = i; j + 1 < m_count; j++) m_order[j] = m_order[j+1];
              m_count--;
              break;
            end
          end
          m_en[r.task_index] = 1'b0;
          due_results.push_back(mk(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      FUNC_NONE: due_results.push_back(mk(ST_OK, 1'b0, '0, 1'b1));
      default: begin
        for (int i = 0; i < m_count; i++) begin
          s = m_order[i];
          m_left[s] = m_left[s] - 32'd1;
          if (m_left[s] == 0) begin
            due_results.push_back(mk(ST_OK, 1'b1, s, 1'b0));
            n++;
            m_left[s] = m_period[s];
          end
        end
        if (n == 0) due_results.push_back(mk(ST_OK, 1'b0, '0, 1'b1));
        else due_results[$].last = 1'b1;
      end
    endcase
  endfunction

  // Sender.
  task automatic send(req_t r);
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.task_index <= r.task_index;
    in_ch.priority_req <= r.priority_req;
    in_ch.period_us <= r.period_us;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    schedule(r);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_and_config(word_t v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_tick_len = v;
    @(posedge clk);
  endtask

  function automatic req_t rq(func_t f, int t, int p, word_t d);
    req_t r;
    r.func = f; r.task_index = slot_t'(t); r.priority_req = prio_t'(p); r.period_us = d;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.func = (k < 35) ? FUNC_TICK : (k < 70) ? FUNC_ENABLE : (k < 97) ? FUNC_DISABLE : FUNC_NONE;
    r.task_index = slot_t'($urandom_range(0, 15));
    r.priority_req = prio_t'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: r.period_us = $urandom;
      1: r.period_us = $urandom_range(0, 9);
      default: r.period_us = $urandom_range(0, 5) * m_tick_len + $urandom_range(0, 3);
    endcase
    return r;
  endfunction

  // Stimulus.
  initial begin
    row_t rows[$];
    row_t w;
    in_ch.valid = 1'b0; in_ch.func = '0; in_ch.task_index = '0;
    in_ch.priority_req = '0; in_ch.period_us = '0;
    sched_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    w.has_exp = 1'b1; w.exp_status = ST_OK; w.req = rq(FUNC_TICK, 0, 0, 0); rows.push_back(w);
    w.exp_status = ST_NOT_EN; w.req = rq(FUNC_DISABLE, 15, 0, 0); rows.push_back(w);
    w.exp_status = ST_OK;     w.req = rq(FUNC_ENABLE, 0, 0, 0); rows.push_back(w);
    w.exp_status = ST_ALREADY; w.req = rq(FUNC_ENABLE, 0, 5, 5000); rows.push_back(w);
    w.exp_status = ST_OK;     w.req = rq(FUNC_NONE, 15, 65535, 32'hffffffff); rows.push_back(w);
    w.has_exp = 1'b0;
    for (int i = 1; i < 16; i++) begin
      w.req = rq(FUNC_ENABLE, i, (i % 3) ? 16'hffff : 16'h0000,
                 (i == 15) ? 32'hffffffff : i * 1000);
      rows.push_back(w);
    end
    w.has_exp = 1'b1; w.exp_status = ST_ALREADY; w.req = rq(FUNC_ENABLE, 0, 1, 1);
    rows.push_back(w);
    w.has_exp = 1'b0; w.req = rq(FUNC_TICK, 0, 0, 0); rows.push_back(w); rows.push_back(w);
    w.req = rq(FUNC_DISABLE, 7, 0, 0); rows.push_back(w);
    w.has_exp = 1'b1; w.exp_status = ST_ALREADY; w.req = rq(FUNC_ENABLE, 3, 0, 0);
    rows.push_back(w);

    foreach (rows[i]) begin
      if (rows[i].has_exp) fixed_status.push_back(rows[i].exp_status);
      else fixed_status.push_back(-1);
      send(rows[i].req);
      idle_gap();
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: drain_and_config(32'd0);
        1: drain_and_config(32'hffffffff);
        2: drain_and_config(32'd1);
        3: drain_and_config(32'd7);
        default: drain_and_config(TICK_LEN_RESET);
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 20) hold_req = 1'b1;
        send(rand_req());
        idle_gap();
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver.
  initial begin
    int stall_len;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end
      stall_len = $urandom_range(0, 7);
      out_ch.ready <= (stall_len < 5) || ((stall_len & 1) == 1);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    res_t got;
    res_t exp;
    int fs;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk(status_t'(out_ch.status), out_ch.fired, out_ch.fired_task, out_ch.last);
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        failed = 1'b1;
      end else begin
        exp = due_results.pop_front();
        if (got !== exp) begin
          $display("%0t: result mismatch expected %h actual %h", $realtime, exp, got);
          failed = 1'b1;
        end
        if (exp.last && fixed_status.size() != 0) begin
          fs = fixed_status.pop_front();
          if (fs >= 0 && got.status != status_t'(fs)) begin
            $display("%0t: status expected %0d actual %0d", $realtime, fs, got.status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (due_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
